FILE: hw/rtl/rbw_pkg.sv
// ----------------------------------------------------------------------------
// rbw_pkg: shared types and constants for the row bulge warp splat
// Field widths, register map, reset values and the item passed from the
// arithmetic pipe to the splat sequencer.
// ----------------------------------------------------------------------------
package rbw_pkg;

   localparam int COORD_BITS     = 12;
   localparam int SIZE_BITS      = COORD_BITS + 1;
   localparam int COLOR_BITS     = 8;
   localparam int GAIN_BITS      = 24;
   localparam int GAIN_FRAC_BITS = 32;
   localparam int DSQ_BITS       = 2 * COORD_BITS;          // (col distance)^2
   localparam int PROD_BITS      = 34;                      // dr * dc^2, max 2^33
   localparam int FULL_BITS      = PROD_BITS + GAIN_BITS;   // gain * dr * dc^2
   localparam int OFF_BITS       = FULL_BITS - GAIN_FRAC_BITS;
   localparam int TR_BITS        = OFF_BITS + 1;
   localparam int SPLAT_NUM      = 5;

   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [SIZE_BITS-1:0] SIZE_MAX          = SIZE_BITS'(1 << COORD_BITS);
   localparam logic [SIZE_BITS-1:0] WIDTH_RESET       = SIZE_BITS'(640);
   localparam logic [SIZE_BITS-1:0] HEIGHT_RESET      = SIZE_BITS'(480);
   localparam logic [GAIN_BITS-1:0] GAIN_RESET        = GAIN_BITS'(35240);

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_WARP_GAIN    = 2'd2
   } reg_index_type;

   // accepted, warped pixel handed to the splat sequencer
   typedef struct packed {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      logic [COLOR_BITS-1:0] blue;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] red;
   } splat_item_type;

   // frame size after saturation, used by both pipe and splat
   typedef struct packed {
      logic [SIZE_BITS-1:0] width;
      logic [SIZE_BITS-1:0] height;
   } frame_size_type;

endpackage

FILE: hw/rtl/rbw_pipe.sv
// ----------------------------------------------------------------------------
// rbw_pipe: five-stage warp arithmetic
// Distances to the frame centre, dc^2, dr*dc^2, gain product and target row
// with range check. All stages move together on adv.
// ----------------------------------------------------------------------------
module rbw_pipe
   import rbw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [COORD_BITS-1:0] in_row,
   input  logic [COORD_BITS-1:0] in_col,
   input  logic [COLOR_BITS-1:0] in_blue,
   input  logic [COLOR_BITS-1:0] in_green,
   input  logic [COLOR_BITS-1:0] in_red,
   input  frame_size_type        size,
   input  logic [GAIN_BITS-1:0]  gain,
   output logic                  out_valid,
   output splat_item_type        out_item
);

   logic [COORD_BITS-1:0] half_w;
   logic [COORD_BITS-1:0] half_h;

   // stage 1: range check and centre distances
   logic                  v1_ff, v1_in;
   splat_item_type        it1_ff, it1_in;
   logic                  below1_ff, below1_in;
   logic [COORD_BITS-1:0] dr1_ff, dr1_in;
   logic [COORD_BITS-1:0] dc1_ff, dc1_in;

   // stage 2: dc^2
   logic                  v2_ff;
   splat_item_type        it2_ff;
   logic                  below2_ff;
   logic [COORD_BITS-1:0] dr2_ff;
   logic [DSQ_BITS-1:0]   dsq2_ff, dsq2_in;

   // stage 3: dr * dc^2
   logic                  v3_ff;
   splat_item_type        it3_ff;
   logic                  below3_ff;
   logic [PROD_BITS-1:0]  prod3_ff, prod3_in;

   // stage 4: gain product, keep integer part
   logic                  v4_ff;
   splat_item_type        it4_ff;
   logic                  below4_ff;
   logic [FULL_BITS-1:0]  full4;
   logic [OFF_BITS-1:0]   off4_ff, off4_in;

   // stage 5: target row and accept
   logic                  v5_ff, v5_in;
   splat_item_type        it5_ff, it5_in;
   logic [TR_BITS-1:0]    tr_wide;
   logic                  move_ok;

   assign half_w = size.width[SIZE_BITS-1:1];
   assign half_h = size.height[SIZE_BITS-1:1];

   always_comb begin
      v1_in        = in_valid
                     && ({1'b0, in_row} < size.height)
                     && ({1'b0, in_col} < size.width);
      it1_in.row   = in_row;
      it1_in.col   = in_col;
      it1_in.blue  = in_blue;
      it1_in.green = in_green;
      it1_in.red   = in_red;
      below1_in    = in_row >= half_h;
      dr1_in       = below1_in ? in_row - half_h : half_h - in_row;
      dc1_in       = (in_col >= half_w) ? in_col - half_w : half_w - in_col;
   end

   assign dsq2_in  = DSQ_BITS'(dc1_ff) * DSQ_BITS'(dc1_ff);
   assign prod3_in = PROD_BITS'(dr2_ff) * PROD_BITS'(dsq2_ff);
   assign full4    = FULL_BITS'(gain) * FULL_BITS'(prod3_ff);
   assign off4_in  = full4[FULL_BITS-1:GAIN_FRAC_BITS];

   always_comb begin
      if (below4_ff) begin
         tr_wide = TR_BITS'(it4_ff.row) + TR_BITS'(off4_ff);
         move_ok = 1'b1;
      end else begin
         tr_wide = TR_BITS'(it4_ff.row) - TR_BITS'(off4_ff);
         move_ok = off4_ff <= OFF_BITS'(it4_ff.row);
      end
      it5_in     = it4_ff;
      it5_in.row = tr_wide[COORD_BITS-1:0];
      v5_in      = v4_ff && move_ok
                   && (tr_wide < TR_BITS'(size.height))
                   && (tr_wide > TR_BITS'(1))
                   && (it4_ff.col > COORD_BITS'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it1_ff    <= it1_in;
         below1_ff <= below1_in;
         dr1_ff    <= dr1_in;
         dc1_ff    <= dc1_in;
         it2_ff    <= it1_ff;
         below2_ff <= below1_ff;
         dr2_ff    <= dr1_ff;
         dsq2_ff   <= dsq2_in;
         it3_ff    <= it2_ff;
         below3_ff <= below2_ff;
         prod3_ff  <= prod3_in;
         it4_ff    <= it3_ff;
         below4_ff <= below3_ff;
         off4_ff   <= off4_in;
         it5_ff    <= it5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_item  = it5_ff;

endmodule

FILE: hw/rtl/rbw_splat.sv
// ----------------------------------------------------------------------------
// rbw_splat: splat sequencer
// Holds one warped pixel and emits its frame-buffer writes one beat at a
// time: target, row+1, row-1, col+1, col-1, edge neighbours skipped.
// ----------------------------------------------------------------------------
module rbw_splat
   import rbw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   input  splat_item_type        load_item,
   input  frame_size_type        size,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_row,
   output logic [COORD_BITS-1:0] rsp_col,
   output logic [COLOR_BITS-1:0] rsp_blue,
   output logic [COLOR_BITS-1:0] rsp_green,
   output logic [COLOR_BITS-1:0] rsp_red,
   output logic                  rsp_last
);

   splat_item_type       item_ff;
   logic [SPLAT_NUM-1:0] rem_ff, rem_in;
   logic [SPLAT_NUM-1:0] rem_rest;
   logic                 row_up_ok;
   logic                 col_up_ok;
   logic                 take;

   // pending writes, bit 0 first; clear lowest set bit per beat
   assign rem_rest  = rem_ff & (rem_ff - SPLAT_NUM'(1));
   assign rsp_valid = |rem_ff;
   assign rsp_last  = ~|rem_rest;
   assign take      = rsp_valid && rsp_ready;
   assign free      = ~rsp_valid || (take && rsp_last);

   assign row_up_ok = (SIZE_BITS'(load_item.row) + SIZE_BITS'(1)) < size.height;
   assign col_up_ok = (SIZE_BITS'(load_item.col) + SIZE_BITS'(1)) < size.width;

   always_comb begin
      rem_in = rem_ff;
      if (take) begin
         rem_in = rem_rest;
      end
      if (free) begin
         rem_in = load_valid ? {1'b1, col_up_ok, 1'b1, row_up_ok, 1'b1}
                             : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load_valid) begin
         item_ff <= load_item;
      end
   end

   always_comb begin
      rsp_row = item_ff.row;
      rsp_col = item_ff.col;
      if (rem_ff[0]) begin
         rsp_row = item_ff.row;
      end else if (rem_ff[1]) begin
         rsp_row = item_ff.row + COORD_BITS'(1);
      end else if (rem_ff[2]) begin
         rsp_row = item_ff.row - COORD_BITS'(1);
      end else if (rem_ff[3]) begin
         rsp_col = item_ff.col + COORD_BITS'(1);
      end else begin
         rsp_col = item_ff.col - COORD_BITS'(1);
      end
   end

   assign rsp_blue  = item_ff.blue;
   assign rsp_green = item_ff.green;
   assign rsp_red   = item_ff.red;

endmodule

FILE: hw/rtl/row_bulge_warp_splat.sv
// ----------------------------------------------------------------------------
// row_bulge_warp_splat: row bulge warp with five-point splat
// Moves each source pixel vertically away from the frame centre and writes
// it to the frame buffer at the target and its four neighbours.
// ----------------------------------------------------------------------------
// A source pixel enters on the req_ channel and leaves as 0 to 5 write beats
// on the rsp_ channel, in the order target, row+1, row-1, col+1, col-1, with
// rsp_last_write set on the final beat of each pixel. Pixels outside the
// frame, or whose target row or column falls outside 2 .. size-1, give no
// beats. A pixel passes through the five arithmetic stages and then the
// splat register before its first beat appears. Pixels without writes
// never hold the input: the splat sequencer sends one beat per cycle while
// rsp_ready is high and holds the pipe until the last beat of a pixel is
// taken. Frame size and gain come from the CSR port (frame_width at 0x0,
// frame_height at 0x4, warp_gain at 0x8) and must only be written while
// the block is idle; sizes above 4096 act as 4096.
// ----------------------------------------------------------------------------
module row_bulge_warp_splat
   import rbw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [COORD_BITS-1:0]    req_src_row,
   input  logic [COORD_BITS-1:0]    req_src_col,
   input  logic [COLOR_BITS-1:0]    req_src_blue,
   input  logic [COLOR_BITS-1:0]    req_src_green,
   input  logic [COLOR_BITS-1:0]    req_src_red,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COORD_BITS-1:0]    rsp_dst_row,
   output logic [COORD_BITS-1:0]    rsp_dst_col,
   output logic [COLOR_BITS-1:0]    rsp_dst_blue,
   output logic [COLOR_BITS-1:0]    rsp_dst_green,
   output logic [COLOR_BITS-1:0]    rsp_dst_red,
   output logic                     rsp_last_write,

   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   // configuration registers, raw as written
   logic [SIZE_BITS-1:0] width_ff, width_in;
   logic [SIZE_BITS-1:0] height_ff, height_in;
   logic [GAIN_BITS-1:0] gain_ff, gain_in;
   logic                 csr_wr;
   reg_index_type        csr_idx;

   frame_size_type       size;
   logic                 adv;
   logic                 pipe_valid;
   splat_item_type       pipe_item;

   // --- CSR port: zero wait states, write on access phase
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      gain_in   = gain_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_FRAME_WIDTH:  width_in  = pwdata[SIZE_BITS-1:0];
            REG_FRAME_HEIGHT: height_in = pwdata[SIZE_BITS-1:0];
            REG_WARP_GAIN:    gain_in   = pwdata[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         gain_ff   <= GAIN_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         gain_ff   <= gain_in;
      end
   end

   always_comb begin
      case (csr_idx)
         REG_FRAME_WIDTH:  prdata = CSR_DATA_BITS'(width_ff);
         REG_FRAME_HEIGHT: prdata = CSR_DATA_BITS'(height_ff);
         REG_WARP_GAIN:    prdata = CSR_DATA_BITS'(gain_ff);
         default:          prdata = '0;
      endcase
   end

   // saturate frame size to the coordinate range
   assign size.width  = (width_ff  > SIZE_MAX) ? SIZE_MAX : width_ff;
   assign size.height = (height_ff > SIZE_MAX) ? SIZE_MAX : height_ff;

   // --- datapath: whole pipe advances whenever the splat stage can take
   // its next pixel; a held pipe keeps every stage and its valid bit.
   assign req_ready = adv;

   rbw_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_row    (req_src_row),
      .in_col    (req_src_col),
      .in_blue   (req_src_blue),
      .in_green  (req_src_green),
      .in_red    (req_src_red),
      .size      (size),
      .gain      (gain_ff),
      .out_valid (pipe_valid),
      .out_item  (pipe_item)
   );

   // splat register doubles as the output register of the rsp_ side
   rbw_splat u_splat (
      .clock      (clock),
      .reset      (reset),
      .load_valid (pipe_valid),
      .load_item  (pipe_item),
      .size       (size),
      .free       (adv),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_row    (rsp_dst_row),
      .rsp_col    (rsp_dst_col),
      .rsp_blue   (rsp_dst_blue),
      .rsp_green  (rsp_dst_green),
      .rsp_red    (rsp_dst_red),
      .rsp_last   (rsp_last_write)
   );

endmodule

FILE: tb/row_bulge_warp_splat_tb.sv
// ----------------------------------------------------------------------------
// row_bulge_warp_splat_tb: self-checking bench for the row bulge warp splat
// Feeds source pixels through the req_ channel under a range of frame sizes
// and gains, predicts every frame-buffer write beat, and checks each rsp_
// beat in order, with random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
module row_bulge_warp_splat_tb;
   import rbw_pkg::*;

   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 12;    // pipe depth is 6, keep some margin
   localparam int STALL_LIMIT   = 4000;  // cycles with no beat before giving up

   typedef enum logic [1:0] {
      IDLE_NONE = 2'd0,
      IDLE_SEND = 2'd1,
      IDLE_RECV = 2'd2,
      IDLE_BOTH = 2'd3
   } idle_mode_type;

   // one frame-buffer write, in the order the block sends its ports
   typedef struct packed {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      logic [COLOR_BITS-1:0] blue;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] red;
      logic                  last;
   } fb_write_type;

   logic                     clock;
   logic                     reset         = 1'b1;

   logic                     req_valid     = 1'b0;
   logic                     req_ready;
   logic [COORD_BITS-1:0]    req_src_row   = '0;
   logic [COORD_BITS-1:0]    req_src_col   = '0;
   logic [COLOR_BITS-1:0]    req_src_blue  = '0;
   logic [COLOR_BITS-1:0]    req_src_green = '0;
   logic [COLOR_BITS-1:0]    req_src_red   = '0;

   logic                     rsp_valid;
   logic                     rsp_ready     = 1'b0;
   logic [COORD_BITS-1:0]    rsp_dst_row;
   logic [COORD_BITS-1:0]    rsp_dst_col;
   logic [COLOR_BITS-1:0]    rsp_dst_blue;
   logic [COLOR_BITS-1:0]    rsp_dst_green;
   logic [COLOR_BITS-1:0]    rsp_dst_red;
   logic                     rsp_last_write;

   logic                     psel          = 1'b0;
   logic                     penable       = 1'b0;
   logic                     pwrite        = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr         = '0;
   logic [CSR_DATA_BITS-1:0] pwdata        = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // bench copy of the registers, updated at the edge the CSR write lands
   logic [SIZE_BITS-1:0]     cfg_width;
   logic [SIZE_BITS-1:0]     cfg_height;
   logic [GAIN_BITS-1:0]     cfg_gain;

   splat_item_type           pixel_q [$];        // source pixels not yet offered
   fb_write_type             pending_writes [$]; // predicted writes, oldest first
   splat_item_type           next_px;

   int unsigned              send_idle_pct  = 0;
   int unsigned              recv_stall_pct = 0;
   int unsigned              hold_asked     = 0; // bumped by the sequence
   int unsigned              hold_granted   = 0; // caught up by the receiver
   int unsigned              hold_left      = 0;
   int unsigned              quiet_cycles   = 0;
   int unsigned              mode_turn      = 0;

   logic                     req_beat       = 1'b0; // req_ beat at last rising edge

   int unsigned              pixels_sent     = 0;
   int unsigned              pixels_splatted = 0;
   int unsigned              writes_seen     = 0;
   int unsigned              mismatches      = 0;
   int unsigned              settings_run    = 1; // reset values count as one

   row_bulge_warp_splat u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_src_row    (req_src_row),
      .req_src_col    (req_src_col),
      .req_src_blue   (req_src_blue),
      .req_src_green  (req_src_green),
      .req_src_red    (req_src_red),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_dst_row    (rsp_dst_row),
      .rsp_dst_col    (rsp_dst_col),
      .rsp_dst_blue   (rsp_dst_blue),
      .rsp_dst_green  (rsp_dst_green),
      .rsp_dst_red    (rsp_dst_red),
      .rsp_last_write (rsp_last_write),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // sizes above 4096 behave as 4096
   function automatic longint unsigned frame_dim(logic [SIZE_BITS-1:0] v);
      return (v > SIZE_MAX) ? longint'(SIZE_MAX) : longint'(v);
   endfunction

   // Warp one accepted pixel and queue the writes it should produce.
   // Offset = floor(gain * |dr| * dc^2 / 2^GAIN_FRAC_BITS); the product is
   // at most 58 bits, so 64-bit math holds it exactly.
   function automatic void warp_pixel(splat_item_type px);
      longint unsigned       w, h, half_w, half_h, row, col, dr, dc, off, tr;
      logic [COORD_BITS-1:0] rows [SPLAT_NUM];
      logic [COORD_BITS-1:0] cols [SPLAT_NUM];
      fb_write_type          wr;
      int                    n;
      n = 0;
      w = frame_dim(cfg_width);
      h = frame_dim(cfg_height);
      row = px.row;
      col = px.col;
      if (row >= h || col >= w)
         return;
      half_h = h / 2;
      half_w = w / 2;
      dr = (row >= half_h) ? row - half_h : half_h - row;
      dc = (col >= half_w) ? col - half_w : half_w - col;
      off = (longint'(cfg_gain) * dr * dc * dc) >> GAIN_FRAC_BITS;
      // at or below centre moves down, above centre moves up
      if (row >= half_h) begin
         tr = row + off;
      end else begin
         if (off > row)
            return;   // pushed past row 0
         tr = row - off;
      end
      if (!(tr < h && tr > 1 && col > 1))
         return;
      // target, row+1, row-1, col+1, col-1; far-edge neighbors dropped
      rows[n] = COORD_BITS'(tr);     cols[n] = COORD_BITS'(col);     n++;
      if (tr + 1 < h) begin
         rows[n] = COORD_BITS'(tr + 1); cols[n] = COORD_BITS'(col); n++;
      end
      rows[n] = COORD_BITS'(tr - 1); cols[n] = COORD_BITS'(col);     n++;
      if (col + 1 < w) begin
         rows[n] = COORD_BITS'(tr); cols[n] = COORD_BITS'(col + 1); n++;
      end
      rows[n] = COORD_BITS'(tr);     cols[n] = COORD_BITS'(col - 1); n++;
      for (int k = 0; k < n; k++) begin
         wr.row   = rows[k];
         wr.col   = cols[k];
         wr.blue  = px.blue;
         wr.green = px.green;
         wr.red   = px.red;
         wr.last  = (k == n - 1);
         pending_writes.push_back(wr);
      end
      pixels_splatted++;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Mostly in-frame pixels, a third of those near the centre where large
   // gains still leave the target inside; the rest is anywhere (noise).
   function automatic splat_item_type make_pixel();
      splat_item_type  px;
      longint unsigned w, h, lo_r, hi_r, lo_c, hi_c;
      int unsigned     pick;
      w = frame_dim(cfg_width);
      h = frame_dim(cfg_height);
      px.blue  = COLOR_BITS'($urandom);
      px.green = COLOR_BITS'($urandom);
      px.red   = COLOR_BITS'($urandom);
      pick = $urandom_range(99);
      if (w == 0 || h == 0 || pick < 15) begin
         px.row = COORD_BITS'($urandom);
         px.col = COORD_BITS'($urandom);
      end else if (pick < 45) begin
         lo_r = (h / 2 > 24) ? h / 2 - 24 : 0;
         hi_r = (h / 2 + 24 < h) ? h / 2 + 24 : h - 1;
         lo_c = (w / 2 > 24) ? w / 2 - 24 : 0;
         hi_c = (w / 2 + 24 < w) ? w / 2 + 24 : w - 1;
         px.row = COORD_BITS'($urandom_range(int'(hi_r), int'(lo_r)));
         px.col = COORD_BITS'($urandom_range(int'(hi_c), int'(lo_c)));
      end else begin
         px.row = COORD_BITS'($urandom_range(int'(h - 1), 0));
         px.col = COORD_BITS'($urandom_range(int'(w - 1), 0));
      end
      return px;
   endfunction

   task automatic push_pixel(int row, int col, int blue, int green, int red);
      splat_item_type px;
      px.row   = COORD_BITS'(row);
      px.col   = COORD_BITS'(col);
      px.blue  = COLOR_BITS'(blue);
      px.green = COLOR_BITS'(green);
      px.red   = COLOR_BITS'(red);
      pixel_q.push_back(px);
   endtask

   task automatic set_idle(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SEND: begin send_idle_pct = 86; recv_stall_pct = 0;  end
         IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 86; end
         default:   begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
   endtask

   // block idle: nothing queued, nothing offered, nothing owed, pipe flushed
   task automatic settle();
      while (pixel_q.size() != 0 || req_valid || pending_writes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup + access cycle; bits above the register width carry junk, which
   // the block must drop
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      logic [31:0] keep;
      keep = (idx == REG_WARP_GAIN) ? 32'h00FF_FFFF : 32'h0000_1FFF;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      pwdata  <= (value & keep) | ($urandom & ~keep);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_FRAME_WIDTH:  cfg_width  = value[SIZE_BITS-1:0];
         REG_FRAME_HEIGHT: cfg_height = value[SIZE_BITS-1:0];
         default:          cfg_gain   = value[GAIN_BITS-1:0];
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic configure(int width, int height, int gain);
      settle();
      csr_write(REG_FRAME_WIDTH, width);
      csr_write(REG_FRAME_HEIGHT, height);
      csr_write(REG_WARP_GAIN, gain);
      settings_run++;
   endtask

   // random pixels in chunks of 25, rotating the idling pattern per chunk
   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            while (pixel_q.size() != 0) @(posedge clock);
            set_idle(idle_mode_type'(mode_turn % 4));
            mode_turn++;
         end
         pixel_q.push_back(make_pixel());
      end
   endtask

   // ------------------------------------------------------------------------
   // Sender: offers the next queued pixel once the previous beat is taken.
   // Valid is only decided when the channel is free, so it never drops early.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat) begin
         if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_px = pixel_q.pop_front();
            req_valid     <= 1'b1;
            req_src_row   <= next_px.row;
            req_src_col   <= next_px.col;
            req_src_blue  <= next_px.blue;
            req_src_green <= next_px.green;
            req_src_red   <= next_px.red;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on request so the block
   // backs up and has to stall its input.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_asked != hold_granted) begin
         hold_granted <= hold_asked;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each write beat against the oldest prediction, then
   // predicts for a pixel accepted on the same edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      fb_write_type seen, want;
      req_beat <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_dst_row, rsp_dst_col, rsp_dst_blue, rsp_dst_green,
                    rsp_dst_red, rsp_last_write};
            writes_seen++;
            if (pending_writes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected write beat row %0d col %0d last %0b",
                           seen.row, seen.col, seen.last);
            end else begin
               want = pending_writes.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ERROR: write beat %0d: expected row %0d col %0d ",
                               "bgr %h %h %h last %0b, got row %0d col %0d ",
                               "bgr %h %h %h last %0b"}, writes_seen,
                              want.row, want.col, want.blue, want.green,
                              want.red, want.last, seen.row, seen.col,
                              seen.blue, seen.green, seen.red, seen.last);
               end
            end
         end
         if (req_valid && req_ready) begin
            warp_pixel(splat_item_type'({req_src_row, req_src_col, req_src_blue,
                                         req_src_green, req_src_red}));
            pixels_sent++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: any beat on either channel or a CSR access counts as progress
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: %0d cycles without a beat, %0d writes still owed",
                     quiet_cycles, pending_writes.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      cfg_width  = WIDTH_RESET;
      cfg_height = HEIGHT_RESET;
      cfg_gain   = GAIN_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values (640x480, small gain), directed corners and edges.
      set_idle(IDLE_NONE);
      push_pixel(240, 320, 8'h00, 8'h00, 8'h00);  // centre, no move
      push_pixel(239, 320, 8'hFF, 8'hFF, 8'hFF);  // just above centre
      push_pixel(0,   0,   8'h00, 8'hFF, 8'h00);  // moved up past row 0
      push_pixel(479, 639, 8'hFF, 8'h00, 8'hFF);  // moved down off the frame
      push_pixel(480, 0,   8'h55, 8'hAA, 8'h55);  // row outside frame
      push_pixel(0,   640, 8'hAA, 8'h55, 8'hAA);  // column outside frame
      push_pixel(4095, 4095, 8'hFF, 8'hFF, 8'hFF);
      push_pixel(240, 1,   8'h12, 8'h34, 8'h56);  // column below 2
      push_pixel(240, 0,   8'h12, 8'h34, 8'h56);
      push_pixel(240, 2,   8'h80, 8'h01, 8'hFE);  // col-1 lands on 1
      push_pixel(240, 639, 8'h01, 8'h80, 8'h7F);  // col+1 off right edge
      push_pixel(479, 320, 8'h7F, 8'hFE, 8'h80);  // row+1 off bottom edge
      push_pixel(2,   320, 8'hC3, 8'h3C, 8'h99);  // target row 2
      push_pixel(1,   320, 8'hC3, 8'h3C, 8'h99);  // target row 1
      push_pixel(300, 500, 8'h0F, 8'hF0, 8'h5A);  // moved down
      push_pixel(200, 100, 8'hF0, 8'h0F, 8'hA5);  // moved up
      settle();
      run_random(60);

      // Full 4096 frame, no warp: every in-frame pixel with row and column of
      // at least 2 splats. The receiver holds off while the sender keeps pushing, so the pipe backs up.
      configure(4096, 4096, 0);
      set_idle(IDLE_NONE);
      push_pixel(4095, 4095, 8'hFF, 8'h00, 8'hFF);
      push_pixel(0,    0,    8'h00, 8'hFF, 8'h00);
      push_pixel(2,    2,    8'hA5, 8'h5A, 8'hA5);
      push_pixel(4095, 2,    8'h5A, 8'hA5, 8'h5A);
      for (int i = 0; i < 60; i++)
         pixel_q.push_back(make_pixel());
      hold_asked++;
      settle();

      // Oversized registers saturate to 4096; maximum gain.
      configure(8191, 8191, 24'hFF_FFFF);
      push_pixel(4095, 4095, 8'h11, 8'h22, 8'h33);
      push_pixel(2048, 2048, 8'h44, 8'h55, 8'h66);
      push_pixel(2047, 2050, 8'h77, 8'h88, 8'h99);
      run_random(50);

      // Empty and tiny frames: nothing fits, or only the pixel at (2,2).
      configure(0, 0, 35240);
      push_pixel(0, 0, 1, 2, 3);
      push_pixel(4095, 4095, 4, 5, 6);
      configure(1, 1, 24'hFF_FFFF);
      push_pixel(0, 0, 7, 8, 9);
      push_pixel(1, 1, 10, 11, 12);
      configure(3, 3, 24'hFF_FFFF);
      push_pixel(2, 2, 8'hDE, 8'hAD, 8'hBE);
      push_pixel(1, 2, 8'hDE, 8'hAD, 8'hBE);
      push_pixel(2, 1, 8'hDE, 8'hAD, 8'hBE);

      // Random frame sizes (some oversized) and gains spread over decades.
      for (int p = 0; p < 4; p++) begin
         configure(($urandom_range(3) == 0) ? $urandom_range(8191, 4097)
                                            : $urandom_range(4096, 2),
                   ($urandom_range(3) == 0) ? $urandom_range(8191, 4097)
                                            : $urandom_range(4096, 2),
                   $urandom_range(24'hFF_FFFF, 0) >> $urandom_range(23, 0));
         run_random(50);
      end

      settle();
      $display({"run covered %0d pixels (%0d splatted, %0d without writes) ",
                "over %0d register settings"},
               pixels_sent, pixels_splatted, pixels_sent - pixels_splatted,
               settings_run);
      $display({"checked %0d write beats under mixed idling and a %0d-cycle ",
                "receiver hold, %0d mismatches"},
               writes_seen, HOLD_CYCLES, mismatches);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/rbw_pkg.sv
hw/rtl/rbw_pipe.sv
hw/rtl/rbw_splat.sv
hw/rtl/row_bulge_warp_splat.sv
tb/row_bulge_warp_splat_tb.sv
